// ----- src/err_pkg.sv -----
// ----------------------------------------------------------------------------
// err_pkg: shared constants and types for the exp range reduction block
// float constants, field widths and the stage payload types
// ----------------------------------------------------------------------------
package err_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned KW = 9;
    localparam int unsigned FracW = 23;
    localparam int unsigned ExpBias = 127;

    // 24-bit significands of log2(e) and ln2 as single-precision values
    localparam logic [23:0] Log2eMant = 24'hB8AA3B;   // 1.44269502 = 0x3FB8AA3B
    localparam logic [7:0]  Log2eExp  = 8'd127;
    localparam logic [23:0] Ln2Mant   = 24'hB17218;   // 0.693147182 = 0x3F317218
    localparam logic [7:0]  Ln2Exp    = 8'd126;

    localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [31:0] SatNeg = 32'h8000_0000;

    typedef struct packed {
        logic        nan;
        logic        sign;
        logic [7:0]  exp_a;
        logic [23:0] mant_a;
        logic        zero;
        logic        sub;
        logic [31:0] raw;
    } in_dec_t;

endpackage

// ----- src/err_if.sv -----
// ----------------------------------------------------------------------------
// err_if: valid/ready stream channel
// carries a payload of configurable width between a source and a sink
// ----------------------------------------------------------------------------
interface err_if #(
    parameter int unsigned W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/exp_range_reduction.sv -----
// an accepted item passes through stage registers 1 to 5 in order, the last
// being the output register; a stall holds every stage in place
// throughput: one item per cycle; the five-stage pipeline advances whenever
// the output register is empty or being taken
// reset: rst_n clears all stage valid bits asynchronously; payloads are not reset
// the pipeline is stateless, items are independent
// ----------------------------------------------------------------------------
// exp_range_reduction: float32 range reduction for exp(x)
// t = x*log2e (rne), Q8.23 conversion, k = floor(t), r = frac*ln2 (rne)
// ----------------------------------------------------------------------------
module exp_range_reduction
    import err_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    err_if.sink    in_ch,
    err_if.source  out_ch
);

    // global advance: whole pipeline moves when output register is empty or being taken
    logic adv;
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // ------------------------------------------------------------------
    // stage 1: decode x, 24x24 product with log2e significand
    // ------------------------------------------------------------------
    logic [31:0] x;
    logic        x_nan;
    logic [23:0] x_mant;
    logic [47:0] p1_next;
    logic [47:0] p1_reg;
    logic        s1_nan_reg, s1_sign_reg, s1_zero_reg;
    logic [9:0]  s1_exp_reg;   // biased exponent of x (log2e adds 0), zero-extended to 10 bit
    logic [9:0]  s1_exp_next;
    logic        x_sub;

    assign x      = in_ch.data;
    assign x_nan  = (x[30:23] == 8'hFF) && (x[22:0] != '0);
    assign x_sub  = (x[30:23] == 8'h00);
    assign x_mant = {!x_sub, x[22:0]};
    assign p1_next = x_mant * Log2eMant;
    // effective biased exponent of x (subnormal uses 1); log2e's unbiased exponent is 0
    assign s1_exp_next = {2'b00, (x_sub ? 8'd1 : x[30:23])};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg      <= p1_next;
            s1_exp_reg  <= s1_exp_next;
            s1_nan_reg  <= x_nan;
            s1_sign_reg <= x[31];
            s1_zero_reg <= (x[30:0] == '0);
        end
    end

    // also keep infinity flag
    logic s1_inf_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            s1_inf_reg <= (x[30:23] == 8'hFF) && (x[22:0] == '0);
    end

    // ------------------------------------------------------------------
    // stage 2: normalize + round product to float t (rne)
    // x*log2e, log2e exponent is 0 unbiased. product of two 1.x in [1,4)
    // subnormal x: product may be small; t = x*1.44 stays below 2^-125 so
    // it always shifts to zero later; either sign gives w=0 (k=0 case)
    // ------------------------------------------------------------------
    logic [23:0] t_mant_next;
    logic [9:0]  t_exp_next;
    logic        hi;
    logic [24:0] rnd;
    logic        g, st;
    always_comb
    begin
        hi = p1_reg[47];
        if (hi)
        begin
            g  = p1_reg[23];
            st = |p1_reg[22:0];
            rnd = {1'b0, p1_reg[47:24]};
            if (g && (st || p1_reg[24]))
                rnd = rnd + 25'd1;
        end
        else
        begin
            g  = p1_reg[22];
            st = |p1_reg[21:0];
            rnd = {1'b0, p1_reg[46:23]};
            if (g && (st || p1_reg[23]))
                rnd = rnd + 25'd1;
        end
        t_exp_next = s1_exp_reg + {9'd0, hi};
        t_mant_next = rnd[23:0];
        if (rnd[24])
        begin
            t_mant_next = 24'h800000;
            t_exp_next  = t_exp_next + 10'd1;
        end
    end

    logic [23:0] t_mant_reg;
    logic [9:0]  t_exp_reg;
    logic        s2_sign_reg, s2_force_reg, s2_tiny_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_mant_reg   <= t_mant_next;
            t_exp_reg    <= t_exp_next;
            s2_sign_reg  <= s1_sign_reg;
            // nan and inf saturate; a finite x whose t overflows is caught by t's exponent
            s2_force_reg <= s1_nan_reg || s1_inf_reg;
            // zero or subnormal x gives t that shifts to zero
            s2_tiny_reg  <= s1_zero_reg || (p1_reg[47:46] == 2'b00);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: Q8.23 conversion with saturation, split k and fraction
    // biased exponent e = t_exp_reg (<=256 when not forced)
    // ------------------------------------------------------------------
    logic [31:0] w_next;
    logic        sat_next;
    logic [31:0] mag;
    logic [9:0]  sh;
    always_comb
    begin
        sat_next = 1'b0;
        mag = '0;
        sh = '0;
        if (s2_force_reg || t_exp_reg >= 10'd255)
            sat_next = 1'b1;
        else if (t_exp_reg >= 10'(ExpBias))
        begin
            sh = t_exp_reg - 10'(ExpBias);
            if (sh > 10'd8)
                sat_next = 1'b1;
            else
                mag = {8'd0, t_mant_reg} << sh[3:0];
        end
        else if (!s2_tiny_reg)
        begin
            sh = 10'(ExpBias) - t_exp_reg;
            mag = (sh >= 10'd32) ? '0 : ({8'd0, t_mant_reg} >> sh[4:0]);
        end
        if (!sat_next && !s2_sign_reg && mag > SatPos)
            sat_next = 1'b1;
        if (!sat_next && s2_sign_reg && mag > SatNeg)
            sat_next = 1'b1;
        if (sat_next)
            w_next = s2_sign_reg ? SatNeg : SatPos;
        else
            w_next = s2_sign_reg ? (32'd0 - mag) : mag;
    end

    logic [31:0] w_reg;
    logic        s3_sat_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg      <= w_next;
            s3_sat_reg <= sat_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: normalize fraction (leading one) and multiply by ln2
    // ------------------------------------------------------------------
    logic [22:0] frac;
    logic [4:0]  lz;
    logic [23:0] fn;
    assign frac = w_reg[22:0];
    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (frac[i])
                lz = 5'(22 - i);
        end
        fn = {frac, 1'b0} << lz;
    end

    logic [47:0] p4_reg;
    logic [4:0]  lz_reg;
    logic        fz_reg;
    logic [8:0]  k4_reg;
    logic        s4_sat_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_reg     <= fn * Ln2Mant;
            lz_reg     <= lz;
            fz_reg     <= (frac == '0);
            k4_reg     <= w_reg[31:23];
            s4_sat_reg <= s3_sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: round r = f*ln2 (rne) and output register
    // fraction value = 1.m * 2^(-1-lz); ln2 = 1.m * 2^-1
    // ------------------------------------------------------------------
    logic [24:0] r_rnd;
    logic [7:0]  r_exp;
    logic [31:0] r_bits;
    always_comb
    begin
        if (p4_reg[47])
        begin
            r_rnd = {1'b0, p4_reg[47:24]};
            if (p4_reg[23] && ((|p4_reg[22:0]) || p4_reg[24]))
                r_rnd = r_rnd + 25'd1;
            r_exp = 8'd126 - 8'(lz_reg);
        end
        else
        begin
            r_rnd = {1'b0, p4_reg[46:23]};
            if (p4_reg[22] && ((|p4_reg[21:0]) || p4_reg[23]))
                r_rnd = r_rnd + 25'd1;
            r_exp = 8'd125 - 8'(lz_reg);
        end
        if (r_rnd[24])
            r_bits = {1'b0, r_exp + 8'd1, 23'd0};
        else
            r_bits = {1'b0, r_exp, r_rnd[22:0]};
        if (fz_reg)
            r_bits = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_ch.data <= {r_bits, k4_reg, s4_sat_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end
    assign out_ch.valid = v5_reg;

    // a stalled result holds while it waits for transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed while stalled");
    // saturation forces the fraction to all ones or zero
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && s3_sat_reg |-> (frac == '0) || (frac == '1))
        else $error("saturated word has bad fraction");
    // zero fraction gives r = +0
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && fz_reg && adv |=> out_ch.data[41:10] == '0)
        else $error("zero fraction not mapped to +0");

endmodule
